/* hdl/assert_macros.svh */
// Assertion macros shared by the QOI decoder RTL.
// Each check is clocked on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Require a property on every rising clock edge.
`define QSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Require that a condition never holds on a rising clock edge.
`define QSD_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

/* hdl/qsd_pkg.sv */
// Shared types, constants and the index hash of the QOI stream decoder.
// No dependencies; every other RTL file imports this package.
`timescale 1ns / 1ps

package qsd_pkg;

  localparam int unsigned INDEX_ENTRIES = 64;
  localparam int unsigned IDX_AW        = $clog2(INDEX_ENTRIES);
  localparam int unsigned HEADER_BYTES  = 14;
  localparam int unsigned HDR_W         = 4;
  localparam int unsigned DIM_W         = 15;
  localparam int unsigned TOTAL_W       = 2 * DIM_W;
  localparam int unsigned RUN_W         = 6;
  localparam int unsigned PDATA_W       = 32;
  localparam int unsigned PADDR_W       = 3;

  // Register byte addresses
  localparam logic [PADDR_W-1:0] ADDR_WIDTH  = 3'd0;
  localparam logic [PADDR_W-1:0] ADDR_HEIGHT = 3'd4;

  // Which payload byte the chunk parser expects next
  localparam logic [3:0] PEND_NONE   = 4'd0;
  localparam logic [3:0] PEND_LUMA   = 4'd1;
  localparam logic [3:0] PEND_RGB_R  = 4'd2;
  localparam logic [3:0] PEND_RGB_G  = 4'd3;
  localparam logic [3:0] PEND_RGB_B  = 4'd4;
  localparam logic [3:0] PEND_RGBA_R = 4'd5;
  localparam logic [3:0] PEND_RGBA_G = 4'd6;
  localparam logic [3:0] PEND_RGBA_B = 4'd7;
  localparam logic [3:0] PEND_RGBA_A = 4'd8;

  // Chunk tags
  localparam logic [7:0] TAG_RGB   = 8'hFE;
  localparam logic [7:0] TAG_RGBA  = 8'hFF;
  localparam logic [1:0] OP_INDEX  = 2'b00;
  localparam logic [1:0] OP_DIFF   = 2'b01;
  localparam logic [1:0] OP_LUMA   = 2'b10;
  localparam logic [1:0] OP_RUN    = 2'b11;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } pixel_t;

  localparam pixel_t PIXEL_RESET = '{r: 8'h00, g: 8'h00, b: 8'h00, a: 8'hFF};

  // One emission job: a pixel repeated count times
  typedef struct packed {
    pixel_t             pixel;
    logic [RUN_W-1:0]   count;
    logic               done;
  } job_t;

  // Index write request
  typedef struct packed {
    logic              en;
    logic [IDX_AW-1:0] addr;
    pixel_t            data;
  } idx_wr_t;

  // Standard QOI hash: (3r + 5g + 7b + 11a) mod 64
  function automatic logic [IDX_AW-1:0] pixel_hash(input pixel_t p);
    logic [IDX_AW-1:0] h;
    h = p.r[IDX_AW-1:0] * IDX_AW'(3) + p.g[IDX_AW-1:0] * IDX_AW'(5)
      + p.b[IDX_AW-1:0] * IDX_AW'(7) + p.a[IDX_AW-1:0] * IDX_AW'(11);
    return h;
  endfunction

endpackage

/* hdl/qsd_index_ram.sv */
// Colour index memory: 64 x 32 bit, one read and one write port, registered read.
// Depends on qsd_pkg. Valid bits stand in for the cleared reset contents.
`timescale 1ns / 1ps

module qsd_index_ram import qsd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  logic [IDX_AW-1:0] rd_addr_i,
  input  idx_wr_t           wr_i,
  output pixel_t            rd_data_o
);

  pixel_t                   mem [INDEX_ENTRIES];
  logic [INDEX_ENTRIES-1:0] valid_q;
  pixel_t                   rd_q;
  logic                     rd_vld_q;
  logic [IDX_AW-1:0]        rd_addr_q;
  logic                     last_vld_q;
  logic [IDX_AW-1:0]        last_addr_q;
  pixel_t                   last_data_q;
  logic                     fwd_hit;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_vld_q   <= 1'b0;
      last_vld_q <= 1'b0;
    end else begin
      if (rd_en_i) begin
        rd_vld_q <= valid_q[rd_addr_i];
      end
      if (wr_i.en) begin
        valid_q[wr_i.addr] <= 1'b1;
        last_vld_q         <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_addr_q <= rd_addr_i;
    end
    if (wr_i.en) begin
      last_addr_q <= wr_i.addr;
      last_data_q <= wr_i.data;
    end
  end

  // The most recent write wins over a read that raced it
  assign fwd_hit   = last_vld_q && (last_addr_q == rd_addr_q);
  assign rd_data_o = fwd_hit  ? last_data_q :
                     rd_vld_q ? rd_q        : '0;

endmodule

/* hdl/qsd_chunk_decoder.sv */
// Chunk parser: holds one byte, updates the current pixel and issues index writes
// and emission jobs. Depends on qsd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module qsd_chunk_decoder import qsd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_accept_i,
  input  logic [7:0]         byte_i,
  input  logic [TOTAL_W-1:0] total_i,
  input  pixel_t             idx_rdata_i,
  input  logic               job_free_i,
  output logic               in_stall_o,
  output logic               job_load_o,
  output job_t               job_o,
  output idx_wr_t            idx_wr_o
);

  logic               s1_vld_q;
  logic [7:0]         s1_byte_q;
  logic [HDR_W-1:0]   hdr_q, hdr_d;
  logic [3:0]         pend_q, pend_d;
  logic [5:0]         luma_q, luma_d;
  logic [TOTAL_W-1:0] emitted_q;
  pixel_t             pix_q, pix_d;
  logic               complete;
  logic [RUN_W-1:0]   run_len;
  logic [RUN_W-1:0]   emit_n;
  logic [TOTAL_W-1:0] left;
  logic               fire;
  logic [7:0]         b;

  assign b = s1_byte_q;

  always_comb begin
    pix_d    = pix_q;
    pend_d   = pend_q;
    luma_d   = luma_q;
    hdr_d    = hdr_q;
    complete = 1'b0;
    run_len  = RUN_W'(1);
    if (!s1_vld_q) begin
      hdr_d = hdr_q;
    end else if (hdr_q != '0) begin
      hdr_d = hdr_q - HDR_W'(1);
    end else if (emitted_q >= total_i) begin
      hdr_d = hdr_q;
    end else begin
      unique case (pend_q) inside
        PEND_LUMA: begin
          pix_d.r  = pix_q.r + {2'b0, luma_q} + {4'b0, b[7:4]} + 8'd216;
          pix_d.g  = pix_q.g + {2'b0, luma_q} + 8'd224;
          pix_d.b  = pix_q.b + {2'b0, luma_q} + {4'b0, b[3:0]} + 8'd216;
          pend_d   = PEND_NONE;
          complete = 1'b1;
        end
        PEND_RGB_R, PEND_RGBA_R: begin
          pix_d.r = b;
          pend_d  = pend_q + 4'd1;
        end
        PEND_RGB_G, PEND_RGBA_G: begin
          pix_d.g = b;
          pend_d  = pend_q + 4'd1;
        end
        PEND_RGBA_B: begin
          pix_d.b = b;
          pend_d  = pend_q + 4'd1;
        end
        PEND_RGB_B: begin
          pix_d.b  = b;
          pend_d   = PEND_NONE;
          complete = 1'b1;
        end
        PEND_RGBA_A: begin
          pix_d.a  = b;
          pend_d   = PEND_NONE;
          complete = 1'b1;
        end
        PEND_NONE: begin
          if (b == TAG_RGB) begin
            pend_d = PEND_RGB_R;
          end else if (b == TAG_RGBA) begin
            pend_d = PEND_RGBA_R;
          end else begin
            unique case (b[7:6])
              OP_INDEX: begin
                pix_d    = idx_rdata_i;
                complete = 1'b1;
              end
              OP_DIFF: begin
                pix_d.r  = pix_q.r + {6'b0, b[5:4]} + 8'd254;
                pix_d.g  = pix_q.g + {6'b0, b[3:2]} + 8'd254;
                pix_d.b  = pix_q.b + {6'b0, b[1:0]} + 8'd254;
                complete = 1'b1;
              end
              OP_LUMA: begin
                luma_d = b[5:0];
                pend_d = PEND_LUMA;
              end
              OP_RUN: begin
                run_len  = b[5:0] + RUN_W'(1);
                complete = 1'b1;
              end
              default: begin
                complete = 1'b0;
              end
            endcase
          end
        end
        default: begin
          pend_d = PEND_NONE;
        end
      endcase
    end
  end

  // Clip the run at the pixels left in the image
  assign left   = total_i - emitted_q;
  assign emit_n = (left < TOTAL_W'(run_len)) ? left[RUN_W-1:0] : run_len;

  // Advance when no job is produced or the output slot frees up
  assign fire       = s1_vld_q && (!complete || job_free_i);
  assign in_stall_o = s1_vld_q && !fire;

  assign job_load_o   = fire && complete;
  assign job_o.pixel  = pix_d;
  assign job_o.count  = emit_n;
  assign job_o.done   = (left == TOTAL_W'(emit_n));

  assign idx_wr_o.en   = fire && complete;
  assign idx_wr_o.addr = pixel_hash(pix_d);
  assign idx_wr_o.data = pix_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      hdr_q     <= HDR_W'(HEADER_BYTES);
      pend_q    <= PEND_NONE;
      luma_q    <= '0;
      emitted_q <= '0;
      pix_q     <= PIXEL_RESET;
    end else begin
      if (in_accept_i) begin
        s1_vld_q <= 1'b1;
      end else if (fire) begin
        s1_vld_q <= 1'b0;
      end
      if (fire) begin
        hdr_q  <= hdr_d;
        pend_q <= pend_d;
        luma_q <= luma_d;
        pix_q  <= pix_d;
        if (complete) begin
          emitted_q <= emitted_q + TOTAL_W'(emit_n);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept_i) begin
      s1_byte_q <= byte_i;
    end
  end

  `QSD_ASSERT(a_hold_stalled_byte, (s1_vld_q && !fire) |=> (s1_vld_q && $stable(s1_byte_q)), "stalled byte lost")
  `QSD_NEVER(a_no_pixel_in_header, s1_vld_q && (hdr_q != '0) && job_load_o, "pixel emitted from header byte")

endmodule

/* hdl/qsd_pixel_out.sv */
// Output register: holds one emission job and repeats its pixel count times.
// Depends on qsd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module qsd_pixel_out import qsd_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   job_load_i,
  input  job_t   job_i,
  input  logic   out_stall_i,
  output logic   job_free_o,
  output logic   out_valid_o,
  output pixel_t pixel_o,
  output logic   last_o,
  output logic   done_o
);

  logic job_vld_q;
  job_t job_q;
  logic out_acc;
  logic last_copy;

  assign out_acc    = job_vld_q && !out_stall_i;
  assign last_copy  = (job_q.count == RUN_W'(1));
  assign job_free_o = !job_vld_q || (out_acc && last_copy);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_vld_q <= 1'b0;
    end else if (job_load_i) begin
      job_vld_q <= 1'b1;
    end else if (out_acc && last_copy) begin
      job_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_load_i) begin
      job_q <= job_i;
    end else if (out_acc) begin
      job_q.count <= job_q.count - RUN_W'(1);
    end
  end

  assign out_valid_o = job_vld_q;
  assign pixel_o     = job_q.pixel;
  assign last_o      = last_copy;
  assign done_o      = job_q.done && last_copy;

  `QSD_NEVER(a_no_empty_job, job_vld_q && (job_q.count == '0), "job held with zero count")
  `QSD_ASSERT(a_run_continues, (out_acc && !last_copy) |=> (job_vld_q && $stable(job_q.pixel)), "run cut short")

endmodule

/* hdl/qoi_stream_decoder.sv */
// QOI stream decoder, one file byte per beat. A completing byte passes the parser stage
// register, then its job loads the output register. Throughput: one byte per cycle, set
// by the one-stage parser and registered index read; a chunk-completing byte waits while
// the output register repeats an earlier run, so a run of n pixels takes n out beats.
// Reset (async, active low) clears control state and index valid bits at once; no clear pass.
// Registers: frame width at 0x0, frame height at 0x4, 15 bits each, reset 1.
`timescale 1ns / 1ps

module qoi_stream_decoder import qsd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  // byte input
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         stream_byte_i,
  // pixel output
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         red_o,
  output logic [7:0]         green_o,
  output logic [7:0]         blue_o,
  output logic [7:0]         alpha_o,
  output logic               last_of_run_o,
  output logic               image_done_o
);

  logic [DIM_W-1:0]   width_q;
  logic [DIM_W-1:0]   height_q;
  logic [TOTAL_W-1:0] total_q;
  logic               cfg_wr;
  logic               in_accept;
  pixel_t             idx_rdata;
  idx_wr_t            idx_wr;
  job_t               job;
  logic               job_load;
  logic               job_free;
  pixel_t             out_pixel;

  // Register writes complete in the access phase; pready is tied high.
  // Bit 2 of the byte address selects the register for writes; reads decode the full address.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(1);
      height_q <= DIM_W'(1);
      total_q  <= TOTAL_W'(1);
    end else begin
      if (cfg_wr && (paddr[2] == ADDR_WIDTH[2])) begin
        width_q <= pwdata[DIM_W-1:0];
      end
      if (cfg_wr && (paddr[2] == ADDR_HEIGHT[2])) begin
        height_q <= pwdata[DIM_W-1:0];
      end
      // Pixel total, registered so the multiply stays off the decode path.
      // Writes must land only while idle (the block does not enforce it); then the lag never shows.
      total_q <= TOTAL_W'(width_q) * TOTAL_W'(height_q);
    end
  end

  always_comb begin
    unique case (paddr)
      ADDR_WIDTH:  prdata = PDATA_W'(width_q);
      ADDR_HEIGHT: prdata = PDATA_W'(height_q);
      default:     prdata = '0;
    endcase
  end

  // Accept a byte whenever the parser stage is empty or advancing
  assign in_accept = in_valid_i && !in_stall_o;

  // The index read is launched with the accepted byte; an INDEX tag's slot is
  // simply its low six bits, so no state is needed to form the address.
  qsd_index_ram u_index_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_accept),
    .rd_addr_i (stream_byte_i[IDX_AW-1:0]),
    .wr_i      (idx_wr),
    .rd_data_o (idx_rdata)
  );

  // Parse the held byte against read data, update the pixel, write the index
  // and hand completed chunks to the output register.
  qsd_chunk_decoder u_decoder (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_accept_i (in_accept),
    .byte_i      (stream_byte_i),
    .total_i     (total_q),
    .idx_rdata_i (idx_rdata),
    .job_free_i  (job_free),
    .in_stall_o  (in_stall_o),
    .job_load_o  (job_load),
    .job_o       (job),
    .idx_wr_o    (idx_wr)
  );

  // Repeat the job's pixel one beat at a time
  qsd_pixel_out u_pixel_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_load_i  (job_load),
    .job_i       (job),
    .out_stall_i (out_stall_i),
    .job_free_o  (job_free),
    .out_valid_o (out_valid_o),
    .pixel_o     (out_pixel),
    .last_o      (last_of_run_o),
    .done_o      (image_done_o)
  );

  assign red_o   = out_pixel.r;
  assign green_o = out_pixel.g;
  assign blue_o  = out_pixel.b;
  assign alpha_o = out_pixel.a;

endmodule

/* bench/tb.sv */
// Self-checking bench for qoi_stream_decoder: byte beats in, RGBA pixel beats out.
// A class scoreboard predicts every pixel; depends on qsd_pkg and the decoder RTL only.
`timescale 1ns / 1ps

module tb;
  import qsd_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 320;  // byte beats to send over the whole run
  localparam int unsigned QUIET_LIMIT  = 2000; // cycles with no beat on either side
  localparam int unsigned SETTLE_CYC   = 8;    // idle cycles before a register write
  localparam int unsigned REPORT_CAP   = 200;

  // One output beat as the bench sees it
  typedef struct packed {
    pixel_t px;
    logic   last;
    logic   done;
  } pixel_beat_t;

  // Predicts the decoded pixels and matches them against the output beats.
  class pixel_scoreboard;
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    pixel_t            cur;
    pixel_t            palette [INDEX_ENTRIES];
    int unsigned       hdr_left;
    logic [3:0]        pend;
    logic [5:0]        luma_dg;
    longint unsigned   emitted;
    pixel_beat_t       pixels_due [$];
    int unsigned       mismatches;

    function new();
      width      = DIM_W'(1);
      height     = DIM_W'(1);
      cur        = PIXEL_RESET;
      foreach (palette[i]) palette[i] = '0;
      hdr_left   = HEADER_BYTES;
      pend       = PEND_NONE;
      luma_dg    = '0;
      emitted    = 0;
      mismatches = 0;
    endfunction

    function longint unsigned pixel_total();
      return longint'(width) * longint'(height);
    endfunction

    function bit image_complete();
      return emitted >= pixel_total();
    endfunction

    function void remember_pixel();
      int unsigned slot;
      slot = (3 * cur.r + 5 * cur.g + 7 * cur.b + 11 * cur.a) % INDEX_ENTRIES;
      palette[slot] = cur;
    endfunction

    // Queue up to count copies of the current pixel, clipped at the image end.
    function void queue_pixels(int unsigned count);
      longint unsigned room;
      int unsigned     n;
      pixel_beat_t     beat;
      room = pixel_total() - emitted;
      n    = (count < room) ? count : int'(room);
      for (int unsigned k = 0; k < n; k++) begin
        emitted++;
        beat.px   = cur;
        beat.last = (k + 1 == n);
        beat.done = (emitted == pixel_total());
        pixels_due.push_back(beat);
      end
    endfunction

    // Advance the decoder state by one accepted byte; return 0 if it was ignored.
    function bit take_byte(logic [7:0] b);
      if (hdr_left > 0) begin
        hdr_left--;
        return 0;
      end
      if (image_complete()) return 0;
      case (pend)
        PEND_LUMA: begin
          cur.r = 8'(cur.r + luma_dg + b[7:4] + 216);
          cur.g = 8'(cur.g + luma_dg + 224);
          cur.b = 8'(cur.b + luma_dg + b[3:0] + 216);
          pend  = PEND_NONE;
          remember_pixel();
          queue_pixels(1);
          return 1;
        end
        PEND_RGB_R, PEND_RGBA_R: begin
          cur.r = b;
          pend  = pend + 4'd1;
          return 1;
        end
        PEND_RGB_G, PEND_RGBA_G: begin
          cur.g = b;
          pend  = pend + 4'd1;
          return 1;
        end
        PEND_RGBA_B: begin
          cur.b = b;
          pend  = pend + 4'd1;
          return 1;
        end
        PEND_RGB_B, PEND_RGBA_A: begin
          if (pend == PEND_RGB_B) cur.b = b;
          else cur.a = b;
          pend = PEND_NONE;
          remember_pixel();
          queue_pixels(1);
          return 1;
        end
        default: ;
      endcase
      // tag byte
      if (b == TAG_RGB) begin
        pend = PEND_RGB_R;
        return 1;
      end
      if (b == TAG_RGBA) begin
        pend = PEND_RGBA_R;
        return 1;
      end
      case (b[7:6])
        OP_INDEX: begin
          cur = palette[b[5:0]];
          remember_pixel();
          queue_pixels(1);
        end
        OP_DIFF: begin
          cur.r = 8'(cur.r + b[5:4] + 254);
          cur.g = 8'(cur.g + b[3:2] + 254);
          cur.b = 8'(cur.b + b[1:0] + 254);
          remember_pixel();
          queue_pixels(1);
        end
        OP_LUMA: begin
          luma_dg = b[5:0];
          pend    = PEND_LUMA;
        end
        default: begin
          remember_pixel();
          queue_pixels(b[5:0] + 1);
        end
      endcase
      return 1;
    endfunction

    task report_mismatch(string msg);
      if (mismatches < REPORT_CAP) $display("MISMATCH: %s", msg);
      mismatches++;
    endtask

    task check_field(string name, int got, int want);
      if (got != want)
        report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
    endtask

    task match_pixel(pixel_beat_t got);
      pixel_beat_t want;
      if (pixels_due.size() == 0) begin
        report_mismatch($sformatf("pixel beat 0x%0h with nothing due", got));
        return;
      end
      want = pixels_due.pop_front();
      check_field("red",         got.px.r, want.px.r);
      check_field("green",       got.px.g, want.px.g);
      check_field("blue",        got.px.b, want.px.b);
      check_field("alpha",       got.px.a, want.px.a);
      check_field("last_of_run", got.last, want.last);
      check_field("image_done",  got.done, want.done);
    endtask
  endclass

  logic               clk_i;
  logic               rst_ni        = 1'b0;
  logic               psel          = 1'b0;
  logic               penable       = 1'b0;
  logic               pwrite        = 1'b0;
  logic [PADDR_W-1:0] paddr         = '0;
  logic [PDATA_W-1:0] pwdata        = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid      = 1'b0;
  logic               in_stall_o;
  logic [7:0]         in_byte       = '0;
  logic               out_valid_o;
  logic               out_stall     = 1'b0;
  logic [7:0]         red_o, green_o, blue_o, alpha_o;
  logic               last_of_run_o, image_done_o;

  pixel_scoreboard    sb;
  int unsigned        fed;           // byte beats accepted so far
  int unsigned        burst_left;    // beats left in the current sender burst
  bit                 gaps_on = 1'b1;

  qoi_stream_decoder u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall_o),
    .stream_byte_i (in_byte),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall),
    .red_o         (red_o),
    .green_o       (green_o),
    .blue_o        (blue_o),
    .alpha_o       (alpha_o),
    .last_of_run_o (last_of_run_o),
    .image_done_o  (image_done_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Receiver: switch between open stretches, scattered stalls and long stall bursts.
  int unsigned stall_hold  = 0;
  int unsigned stall_style = 0;

  always @(negedge clk_i) begin
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      case (stall_style)
        0: begin
          out_stall  <= 1'b0;
          stall_hold <= $urandom_range(8, 40);
        end
        1: out_stall <= ($urandom_range(0, 2) == 0);
        default: begin
          out_stall  <= ~out_stall;
          stall_hold <= $urandom_range(0, 7);
        end
      endcase
      if ($urandom_range(0, 15) == 0) stall_style <= $urandom_range(0, 2);
    end
  end

  // Check every pixel beat at the edge that takes it.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall)
      sb.match_pixel({red_o, green_o, blue_o, alpha_o, last_of_run_o, image_done_o});
  end

  // Watchdog: end the run if neither side moves a beat for too long.
  int unsigned quiet_cyc = 0;

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
      quiet_cyc <= 0;
    end else if (quiet_cyc + 1 >= QUIET_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
      $display("tb failed");
      $finish;
    end else begin
      quiet_cyc <= quiet_cyc + 1;
    end
  end

  // Drop valid and idle for as long as the caller asks.
  task automatic idle(int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
    end
  endtask

  // Offer one byte beat, hold it until taken, then feed it to the scoreboard.
  task automatic push_byte(logic [7:0] b);
    if (burst_left == 0) begin
      if (gaps_on) idle($urandom_range(1, 6));
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk_i); while (in_stall_o);
    void'(sb.take_byte(b));
    fed++;
  endtask

  // Hold off the input until every due pixel has come out.
  task automatic drain();
    idle(1);
    while (sb.pixels_due.size() != 0) @(posedge clk_i);
  endtask

  // One APB transfer: setup cycle, then access until pready.
  task automatic apb_xfer(bit wr, logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] wdata,
                          output logic [PDATA_W-1:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Write a dimension register and read it back.
  task automatic write_dim(logic [PADDR_W-1:0] addr, logic [DIM_W-1:0] val);
    logic [PDATA_W-1:0] rd;
    apb_xfer(1'b1, addr, PDATA_W'(val), rd);
    apb_xfer(1'b0, addr, '0, rd);
    if (rd[DIM_W-1:0] != val)
      sb.report_mismatch($sformatf("reg 0x%0h reads 0x%0h, wrote 0x%0h", addr, rd, val));
  endtask

  // Reprogram the image size only once the decoder is quiet.
  task automatic set_dims(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
    drain();
    idle(SETTLE_CYC);
    write_dim(ADDR_WIDTH, w);
    write_dim(ADDR_HEIGHT, h);
    sb.width  = w;
    sb.height = h;
  endtask

  task automatic push_end_marker();
    repeat (7) push_byte(8'h00);
    push_byte(8'h01);
  endtask

  // One well-formed chunk with random content, or a stray byte now and then.
  task automatic push_chunk();
    case ($urandom_range(0, 9))
      0: begin
        push_byte(TAG_RGB);
        repeat (3) push_byte(8'($urandom_range(0, 255)));
      end
      1: begin
        push_byte(TAG_RGBA);
        repeat (4) push_byte(8'($urandom_range(0, 255)));
      end
      2, 3: push_byte({OP_INDEX, 6'($urandom_range(0, 63))});
      4, 5: push_byte({OP_DIFF, 6'($urandom_range(0, 63))});
      6, 7: begin
        push_byte({OP_LUMA, 6'($urandom_range(0, 63))});
        push_byte(8'($urandom_range(0, 255)));
      end
      // run codes 62 and 63 would collide with the RGB and RGBA tags
      8: push_byte({OP_RUN, 6'($urandom_range(0, 61))});
      default: push_byte(8'($urandom_range(0, 255)));
    endcase
  endtask

  initial begin
    logic [7:0]      hdr [HEADER_BYTES];
    longint unsigned target;
    int unsigned     w;
    int unsigned     h;
    int unsigned     n;
    bit              pressed;

    // header bytes carry tags too; the decoder must skip them all
    hdr = '{8'h71, 8'h6F, 8'h69, 8'h66, 8'h00, 8'hFF, 8'hFE, 8'h80,
            8'hC0, 8'h40, 8'h3F, 8'hBF, 8'h7F, 8'h01};
    sb         = new();
    fed        = 0;
    burst_left = 0;
    pressed    = 1'b0;

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset size is 1x1: skip the header, clip a 62-pixel run to one pixel,
    // then ignore a tag once the image is complete.
    foreach (hdr[i]) push_byte(hdr[i]);
    push_byte({OP_RUN, 6'd61});
    push_byte(TAG_RGB);

    // Zero width: the pixel total is zero, so every byte is dropped.
    set_dims(DIM_W'(0), DIM_W'(7));
    push_byte({OP_DIFF, 6'h15});
    push_byte({OP_RUN, 6'h05});

    // Largest image: walk every chunk type at its field extremes.
    set_dims({DIM_W{1'b1}}, {DIM_W{1'b1}});
    push_byte(TAG_RGB);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'h80);
    push_byte(TAG_RGBA);
    push_byte(8'hFF);
    push_byte(8'h00);
    push_byte(8'h7F);
    push_byte(8'h01);
    push_byte({OP_INDEX, 6'h00});
    push_byte({OP_INDEX, 6'h3F});
    push_byte({OP_DIFF, 6'h00});
    push_byte({OP_DIFF, 6'h3F});
    push_byte({OP_LUMA, 6'h00});
    push_byte(8'h00);
    push_byte({OP_LUMA, 6'h3F});
    push_byte(8'hFF);
    push_byte({OP_RUN, 6'h00});
    push_byte({OP_RUN, 6'd61});

    // Leave room for two pixels: the run is clipped, the end marker ignored.
    set_dims(DIM_W'(1), DIM_W'(sb.emitted + 2));
    push_byte({OP_RUN, 6'd61});
    push_end_marker();

    // Random images of modest size, each a phase of its own.
    while (fed < RANDOM_ITEMS) begin
      if ($urandom_range(0, 5) == 0) begin
        // size at or below what is already out: the image counts as complete
        if ($urandom_range(0, 1) == 1) set_dims(DIM_W'(0), DIM_W'($urandom_range(0, 32767)));
        else set_dims(DIM_W'(1), DIM_W'(1));
        repeat ($urandom_range(2, 6)) push_byte(8'($urandom_range(0, 255)));
      end else begin
        target = sb.emitted + $urandom_range(20, 400);
        w = $urandom_range(1, 64);
        h = 32'((target + w - 1) / w);
        if (h > 32767) h = 32767;
        set_dims(DIM_W'(w), DIM_W'(h));
        gaps_on = ($urandom_range(0, 3) != 0);
        n = $urandom_range(15, 60);
        while (n != 0 && !sb.image_complete() && fed < RANDOM_ITEMS) begin
          push_chunk();
          n--;
          // once, stop sending until the output has caught up
          if (!pressed && fed >= RANDOM_ITEMS / 2) begin
            drain();
            pressed = 1'b1;
          end
        end
        if (sb.image_complete() && $urandom_range(0, 1) == 1) push_end_marker();
      end
    end

    drain();
    repeat (16) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
